>>> rtl/core/lpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types, constants and AES helper functions for the payload cipher.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int unsigned MAX_BLOCKS = 255;
    localparam int unsigned POS_W      = 13;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_BLOCKS * 16);
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_AW       = $clog2(Q_DEPTH);
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR = 2'd2;

    localparam logic [7:0] A_FLAG   = 8'h01;
    localparam logic [3:0] LAST_RND = 4'd10;

    typedef struct packed {
        logic [7:0]  data_in;
        logic        frame_start;
        logic [31:0] frame_count;
        logic        link_direction;
        logic        frame_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       end_of_frame;
        logic       too_long;
    } out_item_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        frame_end;
        logic        too_long;
        logic        need_ks;
        logic [3:0]  idx;
        logic [7:0]  block_num;
        logic [31:0] counter;
        logic        dir;
    } entry_t;

    typedef struct packed {
        logic         start;
        logic [127:0] block;
    } aes_req_t;

    typedef struct packed {
        logic         busy;
        logic         done;
        logic [127:0] result;
    } aes_rsp_t;

    typedef struct packed {
        logic waiting;
        logic ks_fresh;
    } back_status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        gf_double = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte 0 sits in the top bits
    function automatic logic [7:0] get_byte(input logic [127:0] v, input logic [3:0] i);
        get_byte = v[8'(127 - 8 * i) -: 8];
    endfunction

    function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [7:0] rcon);
        logic [31:0] w;
        logic [31:0] n0, n1, n2, n3;
        w  = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
        n0 = rk[127:96] ^ w;
        n1 = rk[95:64] ^ n0;
        n2 = rk[63:32] ^ n1;
        n3 = rk[31:0] ^ n2;
        key_expand = {n0, n1, n2, n3};
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [7:0] sb [16];
        logic [7:0] t  [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] r;
        for (int rr = 0; rr < 4; rr++)
            for (int c = 0; c < 4; c++)
                sb[rr + 4 * c] = SBOX[get_byte(s, 4'(rr + 4 * ((c + rr) % 4)))];
        for (int c = 0; c < 4; c++)
        begin
            a0 = sb[4 * c];
            a1 = sb[4 * c + 1];
            a2 = sb[4 * c + 2];
            a3 = sb[4 * c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            if (last)
            begin
                t[4 * c] = a0; t[4 * c + 1] = a1; t[4 * c + 2] = a2; t[4 * c + 3] = a3;
            end
            else
            begin
                t[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
                t[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
                t[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
                t[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
            r[127 - 8 * i -: 8] = t[i];
        aes_round = r ^ rk;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/lorawan_payload_ctr_cipher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lorawan_payload_ctr_cipher
// LoRaWAN frame payload counter-mode cipher, one byte a beat.
// ----------------------------------------------------------------------------
// Bytes enter through push/full and leave through empty/pop, oldest first.
// The front tracks the byte position in the frame, latches frame counter and
// direction on frame_start, and queues each classified byte (four deep). The
// back pulls from that queue; on the first byte of every 16-byte block it
// runs one AES-128 encryption of the counter block in the iterative round
// unit (one round a cycle, key expanded on the fly), and that first byte
// leaves once the keystream register holds the result. The other 15 bytes
// of the block leave at one a cycle while the output register is free or
// popped; each byte is held in the queue, then the output register. Bytes at
// or past position 4080 pass unchanged with too_long set. Key and device
// address are read when a keystream block starts; write them only while the
// block is idle. Register indices above two are dropped.
// ----------------------------------------------------------------------------
module lorawan_payload_ctr_cipher
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire lpc_pkg::in_item_t                   payload,
    output logic                                     empty,
    input  wire logic                                pop,
    output lpc_pkg::out_item_t                       result,
    input  wire logic                                cfg_we,
    input  wire logic [lpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lpc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import lpc_pkg::*;

    logic [63:0]  key_high_reg, key_low_reg;
    logic [31:0]  dev_addr_reg;
    entry_t       f_entry, q_head;
    logic         q_full, q_empty, q_pop, accept;
    aes_req_t     aes_req;
    aes_rsp_t     aes_rsp;
    back_status_t status;

    assign full   = q_full;
    assign accept = push && !q_full;

    // configuration registers: plain writes, unknown indices dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            dev_addr_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_wdata;
                REG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                REG_DEV_ADDR: dev_addr_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    lpc_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (payload),
        .entry  (f_entry)
    );

    lpc_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .wdata (f_entry),
        .full  (q_full),
        .rd    (q_pop),
        .rdata (q_head),
        .empty (q_empty)
    );

    lpc_aes u_aes
    (
        .clk   (clk),
        .rst_n (rst_n),
        .key   ({key_high_reg, key_low_reg}),
        .req   (aes_req),
        .rsp   (aes_rsp)
    );

    lpc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .node_addr (dev_addr_reg),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .aes_req   (aes_req),
        .aes_rsp   (aes_rsp),
        .result    (result),
        .empty     (empty),
        .pop       (pop),
        .status    (status)
    );

    // a started encryption must be running on the next edge
    a_aes_start: assert property (@(posedge clk) disable iff (!rst_n)
        aes_req.start |=> aes_rsp.busy)
        else $error("keystream request not taken");

    // the round unit runs only on behalf of a waiting back end
    a_aes_owner: assert property (@(posedge clk) disable iff (!rst_n)
        aes_rsp.busy |-> status.waiting)
        else $error("round unit busy without a waiting request");

    // nothing leaves the queue while a keystream block is pending
    a_no_emit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.waiting |-> !q_pop)
        else $error("byte drained during keystream fetch");

endmodule
`default_nettype wire

>>> rtl/core/lpc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_front
// Tracks frame position and latched counter; classifies each accepted byte.
// ----------------------------------------------------------------------------
module lpc_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire lpc_pkg::in_item_t item,
    output lpc_pkg::entry_t       entry
);
    import lpc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      cnt_reg, cnt_next;
    logic             dir_reg, dir_next;
    logic [POS_W-1:0] pos;
    logic             over;

    always_comb
    begin
        pos      = item.frame_start ? '0 : pos_reg;
        cnt_next = item.frame_start ? item.frame_count : cnt_reg;
        dir_next = item.frame_start ? item.link_direction : dir_reg;
        over     = (pos >= POS_LIMIT);
        pos_next = over ? POS_LIMIT : pos + 1'b1;

        entry.data      = item.data_in;
        entry.frame_end = item.frame_end;
        entry.too_long  = over;
        entry.need_ks   = !over && (pos[3:0] == 4'd0);
        entry.idx       = pos[3:0];
        entry.block_num = pos[11:4] + 8'd1;
        entry.counter   = cnt_next;
        entry.dir       = dir_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cnt_reg <= '0;
            dir_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
            dir_reg <= dir_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/lpc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_fifo
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module lpc_fifo
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr,
    input  wire lpc_pkg::entry_t wdata,
    output logic                 full,
    input  wire logic            rd,
    output lpc_pkg::entry_t      rdata,
    output logic                 empty
);
    import lpc_pkg::*;

    entry_t          mem [Q_DEPTH];
    logic [Q_AW:0]   wp_reg, rp_reg;

    assign empty = (wp_reg == rp_reg);
    assign full  = (wp_reg[Q_AW-1:0] == rp_reg[Q_AW-1:0]) && (wp_reg[Q_AW] != rp_reg[Q_AW]);
    assign rdata = mem[rp_reg[Q_AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (wr && !full)
            mem[wp_reg[Q_AW-1:0]] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (wr && !full)
                wp_reg <= wp_reg + 1'b1;
            if (rd && !empty)
                rp_reg <= rp_reg + 1'b1;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/lpc_aes.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_aes
// Iterative AES-128 encipher: one round and one key expansion step a cycle.
// ----------------------------------------------------------------------------
module lpc_aes
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [127:0]     key,
    input  wire lpc_pkg::aes_req_t req,
    output lpc_pkg::aes_rsp_t     rsp
);
    import lpc_pkg::*;

    logic [127:0] st_reg, rk_reg;
    logic [127:0] rk_next;
    logic [7:0]   rcon_reg;
    logic [3:0]   rnd_reg;
    logic         busy_reg, done_reg;

    assign rk_next    = key_expand(rk_reg, rcon_reg);
    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = st_reg;

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            st_reg   <= req.block ^ key;
            rk_reg   <= key;
            rcon_reg <= 8'h01;
        end
        else if (busy_reg)
        begin
            st_reg   <= aes_round(st_reg, rk_next, rnd_reg == LAST_RND);
            rk_reg   <= rk_next;
            rcon_reg <= gf_double(rcon_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= 4'd1;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 4'd1;
                if (rnd_reg == LAST_RND)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/lpc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_back
// Takes queued bytes, fetches a fresh keystream block when due, XORs bytes
// within the length limit and holds the result in the output register.
// ----------------------------------------------------------------------------
module lpc_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [31:0]       node_addr,
    input  wire lpc_pkg::entry_t   head,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output lpc_pkg::aes_req_t      aes_req,
    input  wire lpc_pkg::aes_rsp_t aes_rsp,
    output lpc_pkg::out_item_t     result,
    output logic                   empty,
    input  wire logic              pop,
    output lpc_pkg::back_status_t  status
);
    import lpc_pkg::*;

    typedef enum logic {ST_IDLE, ST_WAIT} state_t;

    state_t       state_reg;
    logic         fresh_reg;
    logic [127:0] ks_reg;
    out_item_t    out_reg;
    logic         ov_reg;
    logic         need, emit;

    assign need  = head.need_ks && !fresh_reg;
    assign emit  = !q_empty && !need && (state_reg == ST_IDLE) && (!ov_reg || pop);
    assign q_pop = emit;

    assign aes_req.start = !q_empty && need && (state_reg == ST_IDLE);
    assign aes_req.block = {A_FLAG, 32'h0, 7'h0, head.dir,
                            node_addr[7:0], node_addr[15:8], node_addr[23:16], node_addr[31:24],
                            head.counter[7:0], head.counter[15:8],
                            head.counter[23:16], head.counter[31:24],
                            8'h00, head.block_num};

    assign result         = out_reg;
    assign empty          = !ov_reg;
    assign status.waiting = (state_reg == ST_WAIT);
    assign status.ks_fresh = fresh_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.data_out     <= head.too_long ? head.data
                                                  : head.data ^ get_byte(ks_reg, head.idx);
            out_reg.end_of_frame <= head.frame_end;
            out_reg.too_long     <= head.too_long;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fresh_reg <= 1'b0;
            ov_reg    <= 1'b0;
            ks_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (aes_req.start)
                        state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (aes_rsp.done)
                    begin
                        ks_reg    <= aes_rsp.result;
                        fresh_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (emit)
            begin
                ov_reg <= 1'b1;
                if (head.need_ks)
                    fresh_reg <= 1'b0;
            end
            else if (pop)
                ov_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire
